// ===== rtl/core/siac_pkg.sv =====
// siac_pkg: constants, types and per-step CORDIC functions for the sun incidence angle block.
// No dependencies; imported by siac_vector and sun_incidence_angle_calc_top.
package siac_pkg;

    localparam int VFB      = 16;         // fraction bits of unit vectors
    localparam int STEPS    = 22;         // CORDIC iterations
    localparam int FULL     = 46080;      // 360 degrees in 1/128 degree
    localparam int HALF     = 23040;
    localparam int QUARTER  = 11520;

    localparam int VW   = VFB + 3;        // vector component width
    localparam int CW   = 33;             // rotation CORDIC x/y width (Q30)
    localparam int ZW   = 24;             // CORDIC angle width (2^-15 degree)
    localparam int AW   = 34;             // vectoring CORDIC x/y width (Q30)
    localparam int ANW  = 25;             // vectoring angle accumulator width
    localparam int MW   = 2 * VW;         // product width
    localparam int PW   = 2 * VW + 1;     // product sum width
    localparam int QS   = 30 - VFB;       // Q30 to vector scale shift
    localparam int SQN  = VFB + 1;        // square root steps
    localparam int SW   = 2 * VFB + 2;    // square root work width
    localparam int VLAT = STEPS + 2;      // vectoring unit register stages

    localparam logic signed [CW-1:0] GAIN  = CW'(64'sd652032874);
    localparam logic signed [CW-1:0] RND_C = CW'(64'sd1 <<< (QS - 1));
    localparam logic signed [PW-1:0] RND_P = PW'(64'sd1 <<< (VFB - 1));
    localparam logic signed [VW-1:0] ONE   = VW'(64'sd1 <<< VFB);
    localparam logic [SW-1:0]        ONE_SQ = SW'(64'd1 << (2 * VFB));

    localparam logic [1:0] CFG_PAN  = 2'd0;
    localparam logic [1:0] CFG_TILT = 2'd1;
    localparam logic [1:0] CFG_HALF = 2'd2;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:STEPS-1] = '{
        24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473, 24'sd117189,
        24'sd58652,   24'sd29333,  24'sd14667,  24'sd7334,   24'sd3667,
        24'sd1833,    24'sd917,    24'sd458,    24'sd229,    24'sd115,
        24'sd57,      24'sd29,     24'sd14,     24'sd7,      24'sd4,
        24'sd2,       24'sd1
    };

    typedef struct packed {
        logic                   neg;
        logic signed [15:0]     ang;
    } t_fold;

    typedef struct packed {
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [ZW-1:0]   z;
        logic                   neg;
    } t_rot;

    typedef struct packed {
        logic signed [AW-1:0]   a;
        logic signed [AW-1:0]   b;
        logic signed [ANW-1:0]  ang;
    } t_vec;

    // reduce to (-180,180], then fold into [-90,90] with a sign flag
    function automatic t_fold fold(input logic signed [15:0] a);
        logic signed [17:0] t;
        t_fold f;
        t = 18'(a);
        if (t > 18'(HALF)) begin
            t = t - 18'(FULL);
        end else if (t <= -18'(HALF)) begin
            t = t + 18'(FULL);
        end
        f.neg = 1'b0;
        if (t > 18'(QUARTER)) begin
            t = t - 18'(HALF);
            f.neg = 1'b1;
        end else if (t < -18'(QUARTER)) begin
            t = t + 18'(HALF);
            f.neg = 1'b1;
        end
        f.ang = t[15:0];
        return f;
    endfunction

    function automatic t_rot rot_step(input t_rot r, input int i);
        t_rot n;
        n = r;
        if (r.z >= 0) begin
            n.x = r.x - (r.y >>> i);
            n.y = r.y + (r.x >>> i);
            n.z = r.z - ATAN_TAB[i];
        end else begin
            n.x = r.x + (r.y >>> i);
            n.y = r.y - (r.x >>> i);
            n.z = r.z + ATAN_TAB[i];
        end
        return n;
    endfunction

    function automatic t_vec vec_step(input t_vec v, input int i);
        t_vec n;
        n = v;
        if (v.a >= 0) begin
            n.b   = v.b + (v.a >>> i);
            n.a   = v.a - (v.b >>> i);
            n.ang = v.ang + ANW'(ATAN_TAB[i]);
        end else begin
            n.b   = v.b - (v.a >>> i);
            n.a   = v.a + (v.b >>> i);
            n.ang = v.ang - ANW'(ATAN_TAB[i]);
        end
        return n;
    endfunction

    // Q30 CORDIC output to vector format, round half up, then apply fold sign
    function automatic logic signed [VW-1:0] rnd_c(input logic signed [CW-1:0] x,
                                                    input logic neg);
        logic signed [CW-1:0] t;
        logic signed [VW-1:0] r;
        t = (x + RND_C) >>> QS;
        r = t[VW-1:0];
        return neg ? -r : r;
    endfunction

    // product sum back to vector format, round half up
    function automatic logic signed [VW-1:0] rq(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + RND_P) >>> VFB;
        return t[VW-1:0];
    endfunction

endpackage

// ===== rtl/core/siac_vector.sv =====
// siac_vector: pipelined vectoring CORDIC giving atan2(a, b) in 1/128 degree, saturated.
// Depends on siac_pkg. Every stage advances only while i_en is high.
module siac_vector
    import siac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [VW-1:0] i_a,
    input  logic signed [VW-1:0] i_b,
    output logic signed [15:0]   o_ang
);

    t_vec r_v [0:STEPS];

    logic signed [AW-1:0]  a0;
    logic signed [AW-1:0]  b0;
    t_vec                  n_v0;
    logic signed [ANW-1:0] rnd_ang;

    always_comb begin
        a0 = AW'(i_a) <<< QS;
        b0 = AW'(i_b) <<< QS;
        n_v0.a   = a0;
        n_v0.b   = b0;
        n_v0.ang = '0;
        // left half plane: pre-rotate by 180 degrees
        if (b0 < 0) begin
            n_v0.ang = (a0 >= 0) ? ANW'(HALF * 256) : -ANW'(HALF * 256);
            n_v0.a   = -a0;
            n_v0.b   = -b0;
        end
        rnd_ang = (r_v[STEPS].ang + ANW'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= n_v0;
            for (int s = 1; s <= STEPS; s++) begin
                r_v[s] <= vec_step(r_v[s-1], s - 1);
            end
            if (rnd_ang > ANW'(HALF)) begin
                o_ang <= 16'(HALF);
            end else if (rnd_ang < -ANW'(HALF)) begin
                o_ang <= -16'(HALF);
            end else begin
                o_ang <= rnd_ang[15:0];
            end
        end
    end

endmodule

// ===== rtl/core/sun_incidence_angle_calc_top.sv =====
// sun_incidence_angle_calc_top: sun direction to panel incidence, longitudinal and
// transverse angles. Depends on siac_pkg and siac_vector.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  input    | i_valid / o_ready          | i_sun_azimuth, i_sun_elevation
//  output   | o_valid / i_ready          | o_incidence_angle, o_longitudinal_angle,
//           |                            | o_transverse_angle, o_in_plane_flag
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One word per cycle sustained while the output is not stalled. The pipe runs through
//  the 22-step rotation CORDIC with its load and rounding stages, seven multiply/round
//  stages, a 17-step square root with its load stage and the 22-step vectoring CORDIC
//  with its load and output stages; then the output register.
//  Reset (i_rst_n low, synchronous) clears valid bits and config registers only.
//  The whole pipe advances when the output register is empty or being taken; a stall
//  freezes every stage, so nothing is lost or repeated.
module sun_incidence_angle_calc_top
    import siac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sun_azimuth,
    input  logic signed [14:0] i_sun_elevation,

    output logic               o_valid,
    input  logic               i_ready,
    output logic        [14:0] o_incidence_angle,
    output logic signed [15:0] o_longitudinal_angle,
    output logic signed [15:0] o_transverse_angle,
    output logic               o_in_plane_flag,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);

    // total register stages ahead of the output register
    localparam int LAT = (STEPS + 1) + 1 + 7 + (SQN + 1) + VLAT;

    typedef struct packed {
        logic signed [VW-1:0] cp;
        logic signed [VW-1:0] sp;
        logic signed [VW-1:0] ct;
        logic signed [VW-1:0] st;
    } t_trig;

    typedef struct packed {
        logic [SW-1:0]        v;
        logic [SW-1:0]        r;
        logic signed [VW-1:0] x2;
        logic signed [VW-1:0] y1;
        logic signed [VW-1:0] z2;
        logic signed [VW-1:0] zc;
        logic                 zf;
    } t_sq;

    // ---- configuration ----
    logic signed [15:0] r_pan;
    logic signed [15:0] r_tilt;
    logic               r_half;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan  <= '0;
            r_tilt <= '0;
            r_half <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAN:  r_pan  <= i_cfg_data;
                CFG_TILT: r_tilt <= i_cfg_data;
                CFG_HALF: r_half <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    // ---- flow control ----
    logic pipe_en;
    logic r_vld [0:LAT-1];
    logic r_out_valid;

    assign pipe_en = !r_out_valid || i_ready;
    assign o_ready = pipe_en;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[LAT-1];
        end
    end

    // ---- sine/cosine lanes: 0 azimuth, 1 elevation, 2 pan, 3 tilt ----
    t_fold fa [0:3];
    t_rot  r_rot [0:STEPS][0:3];
    logic signed [VW-1:0] r_cos [0:3];
    logic signed [VW-1:0] r_sin [0:3];

    always_comb begin
        fa[0] = fold(i_sun_azimuth);
        fa[1] = fold(16'(i_sun_elevation));
        fa[2] = fold(r_pan);
        fa[3] = fold(r_tilt);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int l = 0; l < 4; l++) begin
                r_rot[0][l].x   <= GAIN;
                r_rot[0][l].y   <= '0;
                r_rot[0][l].z   <= ZW'(fa[l].ang) <<< 8;
                r_rot[0][l].neg <= fa[l].neg;
                for (int s = 1; s <= STEPS; s++) begin
                    r_rot[s][l] <= rot_step(r_rot[s-1][l], s - 1);
                end
                r_cos[l] <= rnd_c(r_rot[STEPS][l].x, r_rot[STEPS][l].neg);
                r_sin[l] <= rnd_c(r_rot[STEPS][l].y, r_rot[STEPS][l].neg);
            end
        end
    end

    // ---- vector build and rotations ----
    logic signed [MW-1:0] r_m1_xa, r_m1_ya;
    logic signed [VW-1:0] r_m1_z, r_m2_z, r_m3_z, r_m4_z;
    t_trig                r_m1_t, r_m2_t, r_m3_t, r_m4_t;
    logic signed [VW-1:0] r_m2_x, r_m2_y;
    logic signed [MW-1:0] r_m3_p0, r_m3_p1, r_m3_p2, r_m3_p3;
    logic signed [VW-1:0] r_m4_x1, r_m4_y1;
    logic signed [MW-1:0] r_m5_q0, r_m5_q1, r_m5_q2, r_m5_q3;
    logic signed [VW-1:0] r_m5_y1;
    logic signed [VW-1:0] r_m6_x2, r_m6_y1, r_m6_z2;
    logic                 r_m6_zf;
    logic signed [VW-1:0] r_m7_x2, r_m7_y1, r_m7_z2, r_m7_zc;
    logic                 r_m7_zf;
    logic signed [MW-1:0] r_m7_sq;
    logic signed [VW-1:0] x2_sum, z2_sum, zc;

    always_comb begin
        x2_sum = rq(PW'(r_m5_q0) - PW'(r_m5_q1));
        z2_sum = rq(PW'(r_m5_q2) + PW'(r_m5_q3));
        if (r_m6_z2 > ONE) begin
            zc = ONE;
        end else if (r_m6_z2 < -ONE) begin
            zc = -ONE;
        end else begin
            zc = r_m6_z2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            // x = cos(el)cos(az), y = cos(el)sin(az), z = sin(el)
            r_m1_xa <= r_cos[1] * r_cos[0];
            r_m1_ya <= r_cos[1] * r_sin[0];
            r_m1_z  <= r_sin[1];
            r_m1_t  <= '{cp: r_cos[2], sp: r_sin[2], ct: r_cos[3], st: r_sin[3]};

            r_m2_x  <= rq(PW'(r_m1_xa));
            r_m2_y  <= rq(PW'(r_m1_ya));
            r_m2_z  <= r_m1_z;
            r_m2_t  <= r_m1_t;

            // clockwise pan about Z
            r_m3_p0 <= r_m2_y * r_m2_t.sp;
            r_m3_p1 <= r_m2_x * r_m2_t.cp;
            r_m3_p2 <= r_m2_y * r_m2_t.cp;
            r_m3_p3 <= r_m2_x * r_m2_t.sp;
            r_m3_z  <= r_m2_z;
            r_m3_t  <= r_m2_t;

            r_m4_x1 <= rq(PW'(r_m3_p0) + PW'(r_m3_p1));
            r_m4_y1 <= rq(PW'(r_m3_p2) - PW'(r_m3_p3));
            r_m4_z  <= r_m3_z;
            r_m4_t  <= r_m3_t;

            // clockwise tilt about Y
            r_m5_q0 <= r_m4_x1 * r_m4_t.ct;
            r_m5_q1 <= r_m4_z * r_m4_t.st;
            r_m5_q2 <= r_m4_x1 * r_m4_t.st;
            r_m5_q3 <= r_m4_z * r_m4_t.ct;
            r_m5_y1 <= r_m4_y1;

            // optional half turn about Z
            r_m6_x2 <= r_half ? -x2_sum : x2_sum;
            r_m6_y1 <= r_half ? -r_m5_y1 : r_m5_y1;
            r_m6_z2 <= z2_sum;
            r_m6_zf <= (z2_sum == '0);

            r_m7_x2 <= r_m6_x2;
            r_m7_y1 <= r_m6_y1;
            r_m7_z2 <= r_m6_z2;
            r_m7_zc <= zc;
            r_m7_zf <= r_m6_zf;
            r_m7_sq <= zc * zc;
        end
    end

    // ---- square root of 1 - zc^2, one result bit per stage ----
    t_sq r_sq [0:SQN];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_sq[0].v  <= ONE_SQ - SW'(r_m7_sq);
            r_sq[0].r  <= '0;
            r_sq[0].x2 <= r_m7_x2;
            r_sq[0].y1 <= r_m7_y1;
            r_sq[0].z2 <= r_m7_z2;
            r_sq[0].zc <= r_m7_zc;
            r_sq[0].zf <= r_m7_zf;
            for (int j = 0; j < SQN; j++) begin
                r_sq[j+1].x2 <= r_sq[j].x2;
                r_sq[j+1].y1 <= r_sq[j].y1;
                r_sq[j+1].z2 <= r_sq[j].z2;
                r_sq[j+1].zc <= r_sq[j].zc;
                r_sq[j+1].zf <= r_sq[j].zf;
                if (r_sq[j].v >= r_sq[j].r + (SW'(1) << (2 * (SQN - 1 - j)))) begin
                    r_sq[j+1].v <= r_sq[j].v - r_sq[j].r - (SW'(1) << (2 * (SQN - 1 - j)));
                    r_sq[j+1].r <= (r_sq[j].r >> 1) + (SW'(1) << (2 * (SQN - 1 - j)));
                end else begin
                    r_sq[j+1].v <= r_sq[j].v;
                    r_sq[j+1].r <= r_sq[j].r >> 1;
                end
            end
        end
    end

    // ---- angle extraction ----
    logic signed [15:0] inc_ang, lon_ang, tr_ang;
    logic               r_fd [0:VLAT-1];

    siac_vector u_inc (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (VW'(r_sq[SQN].r)),
        .i_b   (r_sq[SQN].zc),
        .o_ang (inc_ang)
    );

    siac_vector u_lon (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_sq[SQN].y1),
        .i_b   (r_sq[SQN].z2),
        .o_ang (lon_ang)
    );

    siac_vector u_tr (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_sq[SQN].x2),
        .i_b   (r_sq[SQN].z2),
        .o_ang (tr_ang)
    );

    // in-plane flag rides alongside the vectoring units
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_fd[0] <= r_sq[SQN].zf;
            for (int k = 1; k < VLAT; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (r_fd[VLAT-1]) begin
                o_incidence_angle    <= '0;
                o_longitudinal_angle <= '0;
                o_transverse_angle   <= '0;
                o_in_plane_flag      <= 1'b1;
            end else begin
                o_incidence_angle    <= inc_ang[15] ? 15'd0 : inc_ang[14:0];
                o_longitudinal_angle <= lon_ang;
                o_transverse_angle   <= tr_ang;
                o_in_plane_flag      <= 1'b0;
            end
        end
    end

endmodule
